@@ src/blrv_pkg.sv @@
// ----------------------------------------------------------------------------
// blrv_pkg: shared definitions for the bounded list unit
// Word types for both channels, action and status codes, the control word
// handed to every list cell, and the configuration port constants.
// ----------------------------------------------------------------------------
package blrv_pkg;

    // Built number of list cells.
    localparam int unsigned DEFAULT_DEPTH = 32;

    // Field widths fixed by the interface.
    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned POSITION_W = 5;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned COUNT_W    = 6;
    localparam int unsigned CAP_W      = 6;

    // Configuration port.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_CAPACITY = 1'b0;   // register index, paddr[2]
    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(32);

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

    localparam logic [DATA_W-1:0] READ_INVALID = '1;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic signed [DATA_W-1:0] value;
        logic [POSITION_W-1:0] position;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]    entry_count;
    } out_word_t;

    // Broadcast from the controller to every cell for one accepted word.
    typedef struct packed {
        logic              insert_en;
        logic              remove_en;
        logic [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

@@ src/blrv_cell.sv @@
// ----------------------------------------------------------------------------
// blrv_cell: one list entry
// Holds one value, compares it against the search value, passes the
// "match seen" flag to the next cell and takes its upper neighbor's value
// when the list closes a gap.
// ----------------------------------------------------------------------------
module blrv_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CW    = 6
) (
    input  logic                clk,
    input  blrv_pkg::cell_ctl_t ctl,
    input  logic [CW-1:0]       count,
    input  logic [31:0]         next_entry,
    input  logic                found_in,
    output logic [31:0]         entry,
    output logic                found_out
);
    import blrv_pkg::*;

    localparam logic [CW-1:0] IDX      = CW'(INDEX);
    localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              hit;
    logic              take_next;
    logic              load;

    assign hit       = (IDX < count) && (entry_reg == ctl.value);
    assign found_out = found_in | hit;
    // Every cell at or above the first match moves down, as long as a
    // live entry sits above it.
    assign take_next = ctl.remove_en && found_out && (IDX_NEXT < count);
    assign load      = ctl.insert_en && (IDX == count);

    always_comb
    begin
        priority if (load)
        begin
            entry_next = ctl.value;
        end
        else if (take_next)
        begin
            entry_next = next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ src/blrv_out_buf.sv @@
// ----------------------------------------------------------------------------
// blrv_out_buf: result register with a skid stage
// Holds up to two result words so the list keeps accepting while the
// downstream side stalls, until both slots are full.
// ----------------------------------------------------------------------------
module blrv_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  blrv_pkg::out_word_t push_word,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output blrv_pkg::out_word_t out_word
);
    import blrv_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_word_t main_word_reg, main_word_next;
    out_word_t skid_word_reg, skid_word_next;
    logic      pop;

    assign pop = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_word_next  = main_word_reg;
        skid_word_next  = skid_word_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_word_next  = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_word_next  = push_word;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_word_next  = push_word;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_word_next  = push_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_word_reg <= main_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_word_reg;

endmodule

@@ src/bounded_list_remove_by_value_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_list_remove_by_value_unit: bounded list with remove by value
// Each accepted word's result is registered in the output buffer. Throughput:
// one word per cycle while in_stall is low; every action completes in the
// cycle it is accepted, as all chain cells compare and shift in parallel.
// Reset: count clears to zero, capacity returns to 32, both channels empty.
// Entry storage is not reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module bounded_list_remove_by_value_unit #(
    parameter int unsigned DEPTH = blrv_pkg::DEFAULT_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  blrv_pkg::in_word_t                  in_word,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output blrv_pkg::out_word_t                 out_word,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [blrv_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [blrv_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [blrv_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import blrv_pkg::*;

    // Count width holds DEPTH itself; the index width addresses one cell.
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned AW   = $clog2(DEPTH);
    // Common widths for comparing the count against capacity and position.
    localparam int unsigned CAPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int unsigned PW   = (CW > POSITION_W) ? CW : POSITION_W;
    localparam int unsigned IW   = (AW > POSITION_W) ? AW : POSITION_W;

    // ------------------------------------------------------------------
    // Configuration register. Writes land when the access phase completes;
    // a write with paddr[2] set, which misses the capacity register, is dropped.
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write && (paddr[2] == REG_CAPACITY))
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = APB_DATA_W'(capacity_reg);
        end
    end

    // ------------------------------------------------------------------
    // Input acceptance. The output buffer has a skid slot, so the list only
    // stalls when both result slots are occupied.
    // ------------------------------------------------------------------
    logic      accept;
    logic      buf_full;
    out_word_t result;

    assign in_stall = buf_full;
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // List state: the live count and a chain of cells. Each cell receives
    // the same control word; the match flag ripples from cell 0 upward so
    // the first match and every cell above it shift down together.
    // ------------------------------------------------------------------
    logic [CW-1:0] count_reg, count_next;
    cell_ctl_t     ctl;
    logic [31:0]   cell_entry [DEPTH];
    logic          found_chain [DEPTH+1];

    logic          is_insert, is_remove, is_read;
    logic          insert_ok;
    logic          found;
    logic          pos_ok;
    logic [IW-1:0] pos_ext;
    logic [AW-1:0] pos_idx;

    assign is_insert = (in_word.action == ACT_INSERT);
    assign is_remove = (in_word.action == ACT_REMOVE);
    assign is_read   = (in_word.action == ACT_READ);

    // The list has room when the count is below both the capacity register
    // and the number of built cells.
    assign insert_ok = (CAPW'(count_reg) < CAPW'(capacity_reg))
                    && (count_reg < CW'(DEPTH));

    assign ctl.insert_en = accept && is_insert && insert_ok;
    assign ctl.remove_en = accept && is_remove;
    assign ctl.value     = in_word.value;

    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        blrv_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .next_entry (cell_entry[(i + 1 < DEPTH) ? i + 1 : i]),
            .found_in   (found_chain[i]),
            .entry      (cell_entry[i]),
            .found_out  (found_chain[i+1])
        );
    end

    assign found = found_chain[DEPTH];

    // A position below the count is always below DEPTH, so the index cut
    // to the cell address width is safe whenever the read is valid.
    assign pos_ok  = (PW'(in_word.position) < PW'(count_reg));
    assign pos_ext = IW'(in_word.position);
    assign pos_idx = pos_ext[AW-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (ctl.insert_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.remove_en && found)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Result word for the accepted action; the count is the one after it.
    always_comb
    begin
        result.status      = ST_OK;
        result.read_value  = '0;
        result.entry_count = COUNT_W'(count_next);
        unique case (1'b1)
            is_insert:
            begin
                if (!insert_ok)
                begin
                    result.status = ST_FULL;
                end
            end
            is_remove:
            begin
                if (!found)
                begin
                    result.status = ST_NOT_FOUND;
                end
            end
            is_read:
            begin
                if (pos_ok)
                begin
                    result.read_value = cell_entry[pos_idx];
                end
                else
                begin
                    result.status     = ST_BAD_POS;
                    result.read_value = READ_INVALID;
                end
            end
            default:
            begin
                result.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            count_reg    <= count_next;
            capacity_reg <= capacity_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register with skid slot toward the output channel.
    // ------------------------------------------------------------------
    blrv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
